// ===== src/obo_pkg.sv =====
// Shared types and helpers for the oriented box overlap test.
package obo_pkg;

    localparam int IN_BITS  = 272;
    localparam int OUT_BITS = 8;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [19:0] hl;
        logic        [19:0] hw;
    } t_box;

    // first products of one box
    typedef struct {
        t_box               b;
        logic signed [36:0] chl;
        logic signed [36:0] shl;
        logic signed [36:0] shw;
        logic signed [36:0] chw;
    } t_s1_box;

    typedef struct {
        t_s1_box            bx [2];
        logic signed [32:0] sx;
        logic signed [32:0] sy;
    } t_s1;

    // bounds plus projection products for the axes of one box
    typedef struct {
        logic signed [48:0] minx;
        logic signed [48:0] maxx;
        logic signed [48:0] miny;
        logic signed [48:0] maxy;
        logic signed [52:0] m [8];
        logic signed [48:0] l [4];
        logic        [19:0] hl;
        logic        [19:0] hw;
    } t_s2_box;

    typedef struct {
        t_s2_box bx [2];
    } t_s2;

    function automatic logic [36:0] f_abs37(input logic signed [36:0] v);
        return v[36] ? 37'(-v) : 37'(v);
    endfunction

    function automatic logic [53:0] f_abs54(input logic signed [53:0] v);
        return v[53] ? 54'(-v) : 54'(v);
    endfunction

    function automatic logic [49:0] f_abs50(input logic signed [49:0] v);
        return v[49] ? 50'(-v) : 50'(v);
    endfunction

endpackage

// ===== src/obo_prod.sv =====
// Stage 1: extent products of both boxes and the center shift.
module obo_prod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  obo_pkg::t_box i_box [2],
    output logic          o_vld,
    output obo_pkg::t_s1  o_s1
);
    obo_pkg::t_s1 n_s1;
    obo_pkg::t_s1 r_s1;
    logic         r_vld;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_s1.bx[k].b   = i_box[k];
            n_s1.bx[k].chl = 37'(i_box[k].c * $signed({1'b0, i_box[k].hl}));
            n_s1.bx[k].shl = 37'(i_box[k].s * $signed({1'b0, i_box[k].hl}));
            n_s1.bx[k].shw = 37'(i_box[k].s * $signed({1'b0, i_box[k].hw}));
            n_s1.bx[k].chw = 37'(i_box[k].c * $signed({1'b0, i_box[k].hw}));
        end
        n_s1.sx = $signed({i_box[1].cx[31], i_box[1].cx})
                - $signed({i_box[0].cx[31], i_box[0].cx});
        n_s1.sy = $signed({i_box[1].cy[31], i_box[1].cy})
                - $signed({i_box[0].cy[31], i_box[0].cy});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_vld = r_vld;
    assign o_s1  = r_s1;
endmodule

// ===== src/obo_cross.sv =====
// Stage 2: corner bounding boxes and projections onto the four box axes.
module obo_cross (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  obo_pkg::t_s1 i_s1,
    output logic         o_vld,
    output obo_pkg::t_s2 o_s2
);
    obo_pkg::t_s2 n_s2;
    obo_pkg::t_s2 r_s2;
    logic         r_vld;

    always_comb begin
        logic [37:0]        ex;
        logic [37:0]        ey;
        logic signed [48:0] x;
        logic signed [48:0] y;
        logic signed [15:0] pc;
        logic signed [15:0] ps;
        for (int k = 0; k < 2; k++) begin
            ex = {1'b0, obo_pkg::f_abs37(i_s1.bx[k].chl)}
               + {1'b0, obo_pkg::f_abs37(i_s1.bx[k].shw)};
            ey = {1'b0, obo_pkg::f_abs37(i_s1.bx[k].shl)}
               + {1'b0, obo_pkg::f_abs37(i_s1.bx[k].chw)};
            x  = $signed({{2{i_s1.bx[k].b.cx[31]}}, i_s1.bx[k].b.cx, 15'b0});
            y  = $signed({{2{i_s1.bx[k].b.cy[31]}}, i_s1.bx[k].b.cy, 15'b0});
            n_s2.bx[k].minx = x - $signed({11'b0, ex});
            n_s2.bx[k].maxx = x + $signed({11'b0, ex});
            n_s2.bx[k].miny = y - $signed({11'b0, ey});
            n_s2.bx[k].maxy = y + $signed({11'b0, ey});
            pc = i_s1.bx[k].b.c;
            ps = i_s1.bx[k].b.s;
            n_s2.bx[k].m[0] = 53'(i_s1.bx[1-k].chl * pc);
            n_s2.bx[k].m[1] = 53'(i_s1.bx[1-k].shl * ps);
            n_s2.bx[k].m[2] = 53'(i_s1.bx[1-k].shw * pc);
            n_s2.bx[k].m[3] = 53'(i_s1.bx[1-k].chw * ps);
            n_s2.bx[k].m[4] = 53'(i_s1.bx[1-k].chl * ps);
            n_s2.bx[k].m[5] = 53'(i_s1.bx[1-k].shl * pc);
            n_s2.bx[k].m[6] = 53'(i_s1.bx[1-k].shw * ps);
            n_s2.bx[k].m[7] = 53'(i_s1.bx[1-k].chw * pc);
            n_s2.bx[k].l[0] = 49'(i_s1.sx * pc);
            n_s2.bx[k].l[1] = 49'(i_s1.sy * ps);
            n_s2.bx[k].l[2] = 49'(i_s1.sx * ps);
            n_s2.bx[k].l[3] = 49'(i_s1.sy * pc);
            n_s2.bx[k].hl   = i_s1.bx[k].b.hl;
            n_s2.bx[k].hw   = i_s1.bx[k].b.hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_vld = r_vld;
    assign o_s2  = r_s2;
endmodule

// ===== src/obo_axis.sv =====
// Stages 3 to 5: bounding-box reject, projection sums, magnitudes, axis compares.
module obo_axis (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [2:0]   i_en,
    input  logic         i_vld,
    input  obo_pkg::t_s2 i_s2,
    output logic [2:0]   o_vld,
    output logic         o_hit
);
    logic [2:0] r_vld;

    // stage 3
    logic               n_rej,  r_rej3;
    logic signed [53:0] n_r3 [2][4];
    logic signed [53:0] r_r3 [2][4];
    logic signed [49:0] n_l3 [2][2];
    logic signed [49:0] r_l3 [2][2];
    logic        [19:0] r_hl3 [2];
    logic        [19:0] r_hw3 [2];
    // stage 4
    logic               r_rej4;
    logic        [55:0] n_r4 [2][2];
    logic        [55:0] r_r4 [2][2];
    logic        [49:0] n_l4 [2][2];
    logic        [49:0] r_l4 [2][2];
    // stage 5
    logic               n_hit;
    logic               r_hit;

    always_comb begin
        n_rej = (i_s2.bx[1].maxx < i_s2.bx[0].minx) || (i_s2.bx[1].minx > i_s2.bx[0].maxx)
             || (i_s2.bx[1].maxy < i_s2.bx[0].miny) || (i_s2.bx[1].miny > i_s2.bx[0].maxy);
        for (int k = 0; k < 2; k++) begin
            n_r3[k][0] = 54'(i_s2.bx[k].m[0]) + 54'(i_s2.bx[k].m[1]);
            n_r3[k][1] = 54'(i_s2.bx[k].m[2]) - 54'(i_s2.bx[k].m[3]);
            n_r3[k][2] = 54'(i_s2.bx[k].m[4]) - 54'(i_s2.bx[k].m[5]);
            n_r3[k][3] = 54'(i_s2.bx[k].m[6]) + 54'(i_s2.bx[k].m[7]);
            n_l3[k][0] = 50'(i_s2.bx[k].l[0]) + 50'(i_s2.bx[k].l[1]);
            n_l3[k][1] = 50'(i_s2.bx[k].l[2]) - 50'(i_s2.bx[k].l[3]);
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_r4[k][0] = {2'b0, obo_pkg::f_abs54(r_r3[k][0])}
                       + {2'b0, obo_pkg::f_abs54(r_r3[k][1])}
                       + {6'b0, r_hl3[k], 30'b0};
            n_r4[k][1] = {2'b0, obo_pkg::f_abs54(r_r3[k][2])}
                       + {2'b0, obo_pkg::f_abs54(r_r3[k][3])}
                       + {6'b0, r_hw3[k], 30'b0};
            n_l4[k][0] = obo_pkg::f_abs50(r_l3[k][0]);
            n_l4[k][1] = obo_pkg::f_abs50(r_l3[k][1]);
        end
    end

    always_comb begin
        n_hit = !r_rej4;
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 2; j++) begin
                if (r_l4[k][j] > {9'b0, r_r4[k][j][55:15]}) begin
                    n_hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) begin
                r_vld[0] <= i_vld;
            end
            if (i_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (i_en[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rej3 <= n_rej;
            r_r3   <= n_r3;
            r_l3   <= n_l3;
            for (int k = 0; k < 2; k++) begin
                r_hl3[k] <= i_s2.bx[k].hl;
                r_hw3[k] <= i_s2.bx[k].hw;
            end
        end
        if (i_en[1]) begin
            r_rej4 <= r_rej3;
            r_r4   <= n_r4;
            r_l4   <= n_l4;
        end
        if (i_en[2]) begin
            r_hit <= n_hit;
        end
    end

    assign o_vld = r_vld;
    assign o_hit = r_hit;
endmodule

// ===== src/oriented_box_overlap_test.sv =====
// Top level of the oriented box overlap test.
// Five-stage pipeline taking one box pair per beat per cycle unless the output
// stalls; each stage registers its result. Stage 1 forms the extent products,
// stage 2 the bounding boxes and axis projection products, stages 3 to 5 the sums,
// magnitudes and compares. Each stage advances when its successor has room, so
// bubbles close up; under an output stall a beat is taken while any stage is empty.
module oriented_box_overlap_test (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_center_x, a_center_y, a_cos, a_sin, a_half_length, a_half_width,
    // b_center_x, b_center_y, b_cos, b_sin, b_half_length, b_half_width
    input  logic [obo_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // overlap, zero fill
    output logic [obo_pkg::OUT_BITS-1:0] m_axis_tdata
);
    obo_pkg::t_box box [2];
    obo_pkg::t_s1  s1;
    obo_pkg::t_s2  s2;
    logic          v1;
    logic          v2;
    logic [2:0]    vax;
    logic [4:0]    en;
    logic          hit;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            box[k].cx = s_axis_tdata[136*k +: 32];
            box[k].cy = s_axis_tdata[136*k + 32 +: 32];
            box[k].c  = s_axis_tdata[136*k + 64 +: 16];
            box[k].s  = s_axis_tdata[136*k + 80 +: 16];
            box[k].hl = s_axis_tdata[136*k + 96 +: 20];
            box[k].hw = s_axis_tdata[136*k + 116 +: 20];
        end
    end

    assign en[4] = !vax[2] || m_axis_tready;
    assign en[3] = !vax[1] || en[4];
    assign en[2] = !vax[0] || en[3];
    assign en[1] = !v2 || en[2];
    assign en[0] = !v1 || en[1];

    assign s_axis_tready = en[0];

    obo_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[0]),
        .i_vld   (s_axis_tvalid),
        .i_box   (box),
        .o_vld   (v1),
        .o_s1    (s1)
    );

    obo_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[1]),
        .i_vld   (v1),
        .i_s1    (s1),
        .o_vld   (v2),
        .o_s2    (s2)
    );

    obo_axis u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[4:2]),
        .i_vld   (v2),
        .i_s2    (s2),
        .o_vld   (vax),
        .o_hit   (hit)
    );

    assign m_axis_tvalid = vax[2];
    assign m_axis_tdata  = {{(obo_pkg::OUT_BITS-1){1'b0}}, hit};

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> v1)
        else $error("accepted beat did not reach stage 1");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vax[1] && !en[4] |=> vax[1])
        else $error("stage 4 item lost under stall");

    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v2 && !en[2] |=> v2)
        else $error("stage 2 item lost under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule
